/* rtl/wrsi_pkg.sv */
// Shared constants and types of the Wilder RSI window block.
package wrsi_pkg;

	// field and datapath widths
	localparam int PRICE_W      = 32;               // width of the price field
	localparam int PRICE_BITS   = 32;               // price bits that are used
	localparam int FRAC_BITS    = 24;               // fraction bits of the averages
	localparam int AVG_BITS     = 56;               // width of the averages
	localparam int CNT_BITS     = 16;               // sample counter
	localparam int PER_BITS     = 8;                // period register
	localparam int RSI_BITS     = 23;               // result, 16 fraction bits
	localparam int NUM_BITS     = AVG_BITS + PER_BITS;  // smoothing numerator
	localparam int DSR_BITS     = AVG_BITS + 1;     // gain + loss
	localparam int REM_BITS     = AVG_BITS + 2;     // divider partial remainder
	localparam int STEP_BITS    = $clog2(NUM_BITS + 1);

	// configuration port
	localparam int PADDR_BITS   = 2;
	localparam int PDATA_BITS   = 32;
	localparam logic [PADDR_BITS-1:0] ADDR_RSI_PERIOD = '0;
	localparam logic [PER_BITS-1:0]   PERIOD_RESET    = 8'd14;

	// result scaling: 100.0 with 16 fraction bits is 25 << 18
	localparam int RSI_SCALE    = 25;
	localparam int RSI_SHIFT    = 18;
	localparam int RSI_MUL_BITS = AVG_BITS + 5;     // gain * 25
	localparam int RSI_LOW      = RSI_BITS - RSI_SHIFT;
	localparam logic [RSI_BITS-1:0] RSI_NEUTRAL = 23'd3276800;
	localparam logic [RSI_BITS-1:0] RSI_FULL    = 23'd6553600;

	localparam logic [AVG_BITS-1:0] AVG_MAX = '1;
	localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

	// divider command and status
	typedef struct packed {
		logic                 start;
		logic [STEP_BITS-1:0] steps;
	} div_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

/* rtl/wrsi_in_if.sv */
// Price channel: valid/ready handshake with price and window-end mark.
interface wrsi_in_if;
	import wrsi_pkg::*;

	logic               valid;
	logic               ready;
	logic [PRICE_W-1:0] price;
	logic               last_sample;

	modport source(output valid, price, last_sample, input ready);
	modport sink(input valid, price, last_sample, output ready);
endinterface

/* rtl/wrsi_out_if.sv */
// Result channel: valid/ready handshake with the RSI value.
interface wrsi_out_if;
	import wrsi_pkg::*;

	logic                valid;
	logic                ready;
	logic [RSI_BITS-1:0] rsi_value;

	modport source(output valid, rsi_value, input ready);
	modport sink(input valid, rsi_value, output ready);
endinterface

/* rtl/wrsi_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
module wrsi_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wrsi_pkg::div_cmd_t            cmd,
	input  logic [wrsi_pkg::REM_BITS-1:0] rem_init,
	input  logic [wrsi_pkg::NUM_BITS-1:0] dividend,
	input  logic [wrsi_pkg::DSR_BITS-1:0] divisor,
	output wrsi_pkg::div_sts_t            sts,
	output logic [wrsi_pkg::NUM_BITS-1:0] quotient
);
	import wrsi_pkg::*;

	logic [REM_BITS-1:0]  rem_q;
	logic [NUM_BITS-1:0]  dvd_q;
	logic [DSR_BITS-1:0]  dsr_q;
	logic [NUM_BITS-1:0]  quot_q;
	logic [STEP_BITS-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [REM_BITS-1:0]  trial;
	logic [REM_BITS-1:0]  diff;
	logic                 ge;

	// one compare-subtract step; remainder stays below the divisor
	assign trial = {rem_q[REM_BITS-2:0], dvd_q[NUM_BITS-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = trial >= {1'b0, dsr_q};

	// step counter and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (cmd.start) begin
			cnt_q  <= cmd.steps;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == STEP_BITS'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q  <= rem_init;
			dvd_q  <= dividend;
			dsr_q  <= divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff : trial;
			dvd_q  <= {dvd_q[NUM_BITS-2:0], 1'b0};
			quot_q <= {quot_q[NUM_BITS-2:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = quot_q;

endmodule

/* rtl/wilder_rsi_window.sv */
// Wilder RSI over one window of prices. Prices come in one item at a time, oldest
// first; the item with last_sample set closes the window and yields one rsi_value
// (0 to 100, 16 fraction bits), after which the window state clears. Averages are
// kept in 56-bit fixed point with 24 fraction bits; every division truncates. One
// bit-serial divider, one quotient bit per cycle, does all the work. The first price
// of a window goes straight to ST_FIN, a price in the summing phase through ST_ACC.
// The price that completes the first period and every smoothed price run two 64-step
// divisions by the period, one for gain and one for loss, each set up in ST_MUL and
// finished in ST_DIV. A closing price then loads the output register in ST_OUT, after
// ST_RDIV when the 23-step gain/(gain+loss) division runs. The price channel is not
// ready while an item is worked on; a finished result waits in the output register
// and does not hold up the next price unless a second result is ready before the
// first is taken. No clearing pass after reset. rsi_period (address 0) must be
// written only while the block is idle; the block itself does not enforce this.
module wilder_rsi_window (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [wrsi_pkg::PADDR_BITS-1:0] paddr,
	input  logic [wrsi_pkg::PDATA_BITS-1:0] pwdata,
	output logic [wrsi_pkg::PDATA_BITS-1:0] prdata,
	output logic                            pready,
	wrsi_in_if.sink                         sample_ch,
	wrsi_out_if.source                      result_ch
);
	import wrsi_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_ACC, ST_MUL, ST_DIV, ST_FIN, ST_RDIV, ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_NONE, PH_SUM, PH_SUM_DIV, PH_SMOOTH
	} phase_t;

	typedef enum logic {
		LANE_GAIN, LANE_LOSS
	} lane_t;

	state_t                state_q;
	phase_t                phase_q;
	lane_t                 lane_q;
	logic [PER_BITS-1:0]   per_q;
	logic [PRICE_BITS-1:0] prev_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [AVG_BITS-1:0]   gain_q;
	logic [AVG_BITS-1:0]   loss_q;
	logic [AVG_BITS-1:0]   up_q;
	logic [AVG_BITS-1:0]   dn_q;
	logic                  last_q;
	logic [RSI_BITS-1:0]   res_q;
	logic [RSI_BITS-1:0]   rsi_q;
	logic                  out_valid_q;

	logic [PER_BITS-1:0]     per_eff;
	logic [CNT_BITS-1:0]     cnt_per;
	logic                    s_accept;
	logic                    cfg_wr;
	logic [PRICE_BITS-1:0]   p;
	logic [AVG_BITS-1:0]     avg_sel;
	logic [AVG_BITS-1:0]     mv_sel;
	logic [NUM_BITS-1:0]     mul_sum;
	logic [RSI_MUL_BITS-1:0] g25;
	logic                    ratio_go;

	div_cmd_t              div_cmd;
	div_sts_t              div_sts;
	logic [REM_BITS-1:0]   div_rem;
	logic [NUM_BITS-1:0]   div_dvd;
	logic [DSR_BITS-1:0]   div_dsr;
	logic [NUM_BITS-1:0]   div_quot;

	// price move to fixed point, saturating at the average width
	function automatic logic [AVG_BITS-1:0] to_fixed(input logic [PRICE_BITS-1:0] mv);
		logic [PRICE_BITS+AVG_BITS-1:0] w;
		w = (PRICE_BITS+AVG_BITS)'(mv) << FRAC_BITS;
		return (w > (PRICE_BITS+AVG_BITS)'(AVG_MAX)) ? AVG_MAX : w[AVG_BITS-1:0];
	endfunction

	function automatic logic [AVG_BITS-1:0] sat_add(input logic [AVG_BITS-1:0] a,
			input logic [AVG_BITS-1:0] b);
		logic [AVG_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[AVG_BITS] ? AVG_MAX : s[AVG_BITS-1:0];
	endfunction

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_RSI_PERIOD);
	assign prdata = (paddr == ADDR_RSI_PERIOD) ? PDATA_BITS'(per_q) : '0;

	// a period of zero acts as one
	assign per_eff  = (per_q == '0) ? PER_BITS'(1) : per_q;
	assign cnt_per  = CNT_BITS'(per_eff);
	assign s_accept = sample_ch.valid && sample_ch.ready;
	assign p        = sample_ch.price[PRICE_BITS-1:0];

	// smoothing numerator: avg * (period - 1) + move
	assign avg_sel = (lane_q == LANE_GAIN) ? gain_q : loss_q;
	assign mv_sel  = (lane_q == LANE_GAIN) ? up_q : dn_q;
	assign mul_sum = NUM_BITS'(avg_sel) * NUM_BITS'(per_eff - 1'b1) + NUM_BITS'(mv_sel);

	// ratio numerator 6553600 * gain = (25 * gain) << 18
	assign g25      = RSI_MUL_BITS'(gain_q) * RSI_MUL_BITS'(RSI_SCALE);
	assign ratio_go = (state_q == ST_FIN) && last_q && (cnt_q > cnt_per) && (loss_q != '0);

	// divider operands
	always_comb begin
		div_cmd = '0;
		div_rem = '0;
		div_dvd = '0;
		div_dsr = DSR_BITS'(per_eff);
		if (state_q == ST_MUL) begin
			div_cmd.start = 1'b1;
			div_cmd.steps = STEP_BITS'(NUM_BITS);
			div_dvd = (phase_q == PH_SMOOTH) ? mul_sum : NUM_BITS'(avg_sel);
		end else if (ratio_go) begin
			// quotient fits in RSI_BITS, so start from the top of the numerator
			div_cmd.start = 1'b1;
			div_cmd.steps = STEP_BITS'(RSI_BITS);
			div_rem = REM_BITS'(g25[RSI_MUL_BITS-1:RSI_LOW]);
			div_dvd = {g25[RSI_LOW-1:0], {(NUM_BITS-RSI_LOW){1'b0}}};
			div_dsr = DSR_BITS'(gain_q) + DSR_BITS'(loss_q);
		end
	end

	wrsi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (div_cmd),
		.rem_init (div_rem),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.sts      (div_sts),
		.quotient (div_quot)
	);

	// up and down moves of the accepted price
	always_ff @(posedge clk) begin
		if (s_accept) begin
			up_q <= (p > prev_q) ? to_fixed(p - prev_q) : '0;
			dn_q <= (prev_q > p) ? to_fixed(prev_q - p) : '0;
		end
	end

	// sequencer, window state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_NONE;
			lane_q      <= LANE_GAIN;
			per_q       <= PERIOD_RESET;
			prev_q      <= '0;
			cnt_q       <= '0;
			gain_q      <= '0;
			loss_q      <= '0;
			last_q      <= 1'b0;
			res_q       <= '0;
			rsi_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				per_q <= pwdata[PER_BITS-1:0];
			end
			// ST_OUT owns the output register while it loads the next result
			if (result_ch.valid && result_ch.ready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						prev_q <= p;
						cnt_q  <= (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;
						last_q <= sample_ch.last_sample;
						lane_q <= LANE_GAIN;
						if (cnt_q == '0) begin
							phase_q <= PH_NONE;
							state_q <= ST_FIN;
						end else if (cnt_q < cnt_per) begin
							phase_q <= PH_SUM;
							state_q <= ST_ACC;
						end else if (cnt_q == cnt_per) begin
							phase_q <= PH_SUM_DIV;
							state_q <= ST_ACC;
						end else begin
							phase_q <= PH_SMOOTH;
							state_q <= ST_MUL;
						end
					end
				end
				ST_ACC: begin
					gain_q  <= sat_add(gain_q, up_q);
					loss_q  <= sat_add(loss_q, dn_q);
					state_q <= (phase_q == PH_SUM_DIV) ? ST_MUL : ST_FIN;
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_sts.done) begin
						if (lane_q == LANE_GAIN) begin
							gain_q  <= div_quot[AVG_BITS-1:0];
							lane_q  <= LANE_LOSS;
							state_q <= ST_MUL;
						end else begin
							loss_q  <= div_quot[AVG_BITS-1:0];
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (cnt_q <= cnt_per) begin
						res_q   <= RSI_NEUTRAL;
						state_q <= ST_OUT;
					end else if (loss_q == '0) begin
						res_q   <= RSI_FULL;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_RDIV;
					end
				end
				ST_RDIV: begin
					if (div_sts.done) begin
						res_q   <= div_quot[RSI_BITS-1:0];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// wait for the output register, then clear the window
					if (!out_valid_q || result_ch.ready) begin
						out_valid_q <= 1'b1;
						rsi_q       <= res_q;
						prev_q      <= '0;
						cnt_q       <= '0;
						gain_q      <= '0;
						loss_q      <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign sample_ch.ready     = (state_q == ST_IDLE);
	assign result_ch.valid     = out_valid_q;
	assign result_ch.rsi_value = rsi_q;

endmodule

/* rtl/wrsi_checker.sv */
// Port-level checks of the Wilder RSI window block, bound to the top level.
module wrsi_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_valid,
	input logic                          s_ready,
	input logic                          r_valid,
	input logic                          r_ready,
	input logic [wrsi_pkg::RSI_BITS-1:0] r_value
);
	import wrsi_pkg::*;

	// result never exceeds 100
	a_rsi_range: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid |-> (r_value <= RSI_FULL))
		else $error("rsi_value above 100");

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(r_value))
		else $error("result changed while stalled");

	// one price at a time: busy after each accepted item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_valid && s_ready |=> !s_ready)
		else $error("price accepted while busy");

	// a result never appears right after a price is taken
	a_res_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(r_valid) |-> !$past(s_valid && s_ready))
		else $error("result too early");

endmodule

bind wilder_rsi_window wrsi_checker u_wrsi_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_valid (sample_ch.valid),
	.s_ready (sample_ch.ready),
	.r_valid (result_ch.valid),
	.r_ready (result_ch.ready),
	.r_value (result_ch.rsi_value)
);
